[hw/rtl/yuv2bgr_pkg.sv]
// ----------------------------------------------------------------------------
// yuv2bgr_pkg
// Shared types and constants for the 4:2:0 YUV to BGR pixel-pair converter.
// ----------------------------------------------------------------------------
package yuv2bgr_pkg;

    // field and register widths
    localparam int SAMPLE_W = 8;
    localparam int WP_W     = 12;   // width_pairs register
    localparam int FR_W     = 13;   // frame_rows register
    localparam int ROW_W    = 12;   // row counter
    localparam int CFG_W    = 13;   // config data bus
    localparam int TERM_W   = 19;   // signed product terms
    localparam int SUM_W    = 20;   // signed channel accumulator

    // register indexes
    localparam logic CFG_WIDTH_PAIRS = 1'b0;
    localparam logic CFG_FRAME_ROWS  = 1'b1;

    localparam logic [WP_W-1:0] WP_RESET = WP_W'(960);
    localparam logic [FR_W-1:0] FR_RESET = FR_W'(1080);
    localparam logic [FR_W-1:0] ROWS_LIMIT = FR_W'(4096);

    // BT.601 studio range coefficients, 8 fractional bits
    localparam logic signed [TERM_W-1:0] C_Y   = TERM_W'(298);
    localparam logic signed [TERM_W-1:0] C_BU  = TERM_W'(516);
    localparam logic signed [TERM_W-1:0] C_GU  = TERM_W'(100);
    localparam logic signed [TERM_W-1:0] C_GV  = TERM_W'(208);
    localparam logic signed [TERM_W-1:0] C_RV  = TERM_W'(409);
    localparam logic signed [SUM_W-1:0]  ROUND = SUM_W'(128);
    localparam logic signed [9:0]        Y_OFS = 10'sd16;
    localparam logic signed [9:0]        C_OFS = 10'sd128;
    localparam logic [SAMPLE_W-1:0]      BYTE_MAX = 8'd255;

    // stage 1 -> stage 2: samples with the chroma already chosen
    typedef struct packed {
        logic [SAMPLE_W-1:0] luma_l;
        logic [SAMPLE_W-1:0] luma_r;
        logic [SAMPLE_W-1:0] cb;
        logic [SAMPLE_W-1:0] cr;
        logic                row_end;
        logic                frame_end;
    } t_pair;

    // stage 2 -> stage 3: scaled luma and chroma terms
    typedef struct packed {
        logic signed [TERM_W-1:0] y_l;
        logic signed [TERM_W-1:0] y_r;
        logic signed [TERM_W-1:0] t_b;
        logic signed [TERM_W-1:0] t_g;
        logic signed [TERM_W-1:0] t_r;
        logic                     row_end;
        logic                     frame_end;
    } t_terms;

    // result pair
    typedef struct packed {
        logic [SAMPLE_W-1:0] blue_l;
        logic [SAMPLE_W-1:0] green_l;
        logic [SAMPLE_W-1:0] red_l;
        logic [SAMPLE_W-1:0] blue_r;
        logic [SAMPLE_W-1:0] green_r;
        logic [SAMPLE_W-1:0] red_r;
        logic                row_end;
        logic                frame_end;
    } t_bgr;

endpackage

[hw/rtl/yuv2bgr_pix_if.sv]
// ----------------------------------------------------------------------------
// yuv2bgr_pix_if
// Input channel: one luma pair and one chroma pair per transfer.
// ----------------------------------------------------------------------------
interface yuv2bgr_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] luma_left;
    logic [7:0] luma_right;
    logic [7:0] chroma_u;
    logic [7:0] chroma_v;

    modport source (output valid, luma_left, luma_right, chroma_u, chroma_v, input ready);
    modport sink   (input valid, luma_left, luma_right, chroma_u, chroma_v, output ready);
endinterface

[hw/rtl/yuv2bgr_bgr_if.sv]
// ----------------------------------------------------------------------------
// yuv2bgr_bgr_if
// Output channel: one BGR pixel pair with row and frame end flags.
// ----------------------------------------------------------------------------
interface yuv2bgr_bgr_if;
    logic       valid;
    logic       ready;
    logic [7:0] blue_left;
    logic [7:0] green_left;
    logic [7:0] red_left;
    logic [7:0] blue_right;
    logic [7:0] green_right;
    logic [7:0] red_right;
    logic       row_end;
    logic       frame_end;

    modport source (output valid, blue_left, green_left, red_left, blue_right,
                    green_right, red_right, row_end, frame_end, input ready);
    modport sink   (input valid, blue_left, green_left, red_left, blue_right,
                    green_right, red_right, row_end, frame_end, output ready);
endinterface

[hw/rtl/yuv2bgr_cfg_if.sv]
// ----------------------------------------------------------------------------
// yuv2bgr_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface yuv2bgr_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [12:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[hw/rtl/yuv2bgr_front.sv]
// ----------------------------------------------------------------------------
// yuv2bgr_front
// Config registers, column/row counters, chroma line store and stage 1.
// ----------------------------------------------------------------------------
module yuv2bgr_front #(
    parameter int MAX_LINE_PAIRS = 2048
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    yuv2bgr_cfg_if.sink            i_cfg,
    yuv2bgr_pix_if.sink            i_pix,
    output logic                   o_valid,
    input  logic                   i_ready,
    output yuv2bgr_pkg::t_pair     o_pair
);
    import yuv2bgr_pkg::*;

    localparam int CW   = (MAX_LINE_PAIRS > 1) ? $clog2(MAX_LINE_PAIRS) : 1;
    localparam int CMPW = ((CW > WP_W) ? CW : WP_W) + 1;

    logic [WP_W-1:0]  r_width_pairs;
    logic [FR_W-1:0]  r_frame_rows;
    logic [CW-1:0]    r_col;
    logic [ROW_W-1:0] r_row;
    logic [15:0]      r_line [MAX_LINE_PAIRS];
    logic [15:0]      r_rd;

    logic             r_valid;
    logic [7:0]       r_luma_l, r_luma_r, r_cb, r_cr;
    logic             r_odd, r_row_end, r_frame_end;

    logic             accept;
    logic [CMPW-1:0]  w_ext, wp_eff, col_nx;
    logic [FR_W-1:0]  fr_eff, row_nx;
    logic             row_end, frame_end;

    assign i_cfg.ready = 1'b1;
    assign i_pix.ready = !r_valid || i_ready;
    assign accept      = i_pix.valid && i_pix.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_pairs <= WP_RESET;
            r_frame_rows  <= FR_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_WIDTH_PAIRS: r_width_pairs <= i_cfg.data[WP_W-1:0];
                CFG_FRAME_ROWS:  r_frame_rows  <= i_cfg.data[FR_W-1:0];
                default: ;
            endcase
        end
    end

    // effective sizes: zero acts as one, oversize saturates
    always_comb begin
        w_ext = CMPW'(r_width_pairs);
        if (w_ext == '0) begin
            wp_eff = CMPW'(1);
        end else if (w_ext > CMPW'(MAX_LINE_PAIRS)) begin
            wp_eff = CMPW'(MAX_LINE_PAIRS);
        end else begin
            wp_eff = w_ext;
        end
        if (r_frame_rows == '0) begin
            fr_eff = FR_W'(1);
        end else if (r_frame_rows > ROWS_LIMIT) begin
            fr_eff = ROWS_LIMIT;
        end else begin
            fr_eff = r_frame_rows;
        end
        col_nx    = CMPW'(r_col) + CMPW'(1);
        row_nx    = FR_W'(r_row) + FR_W'(1);
        row_end   = col_nx >= wp_eff;
        frame_end = row_end && (row_nx >= fr_eff);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            if (row_end) begin
                r_col <= '0;
                r_row <= frame_end ? '0 : row_nx[ROW_W-1:0];
            end else begin
                r_col <= col_nx[CW-1:0];
            end
        end
    end

    // line store: even rows write, odd rows read back
    always_ff @(posedge i_clk) begin
        if (accept) begin
            if (!r_row[0]) begin
                r_line[r_col] <= {i_pix.chroma_u, i_pix.chroma_v};
            end else begin
                r_rd <= r_line[r_col];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_pix.ready) begin
            r_valid <= i_pix.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_luma_l    <= i_pix.luma_left;
            r_luma_r    <= i_pix.luma_right;
            r_cb        <= i_pix.chroma_u;
            r_cr        <= i_pix.chroma_v;
            r_odd       <= r_row[0];
            r_row_end   <= row_end;
            r_frame_end <= frame_end;
        end
    end

    assign o_valid          = r_valid;
    assign o_pair.luma_l    = r_luma_l;
    assign o_pair.luma_r    = r_luma_r;
    assign o_pair.cb        = r_odd ? r_rd[15:8] : r_cb;
    assign o_pair.cr        = r_odd ? r_rd[7:0]  : r_cr;
    assign o_pair.row_end   = r_row_end;
    assign o_pair.frame_end = r_frame_end;

endmodule

[hw/rtl/yuv2bgr_terms.sv]
// ----------------------------------------------------------------------------
// yuv2bgr_terms
// Stage 2: constant multiplications of offset luma and chroma.
// ----------------------------------------------------------------------------
module yuv2bgr_terms (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  yuv2bgr_pkg::t_pair     i_pair,
    output logic                   o_valid,
    input  logic                   i_ready,
    output yuv2bgr_pkg::t_terms    o_terms
);
    import yuv2bgr_pkg::*;

    logic                     r_valid;
    t_terms                   r_terms;
    t_terms                   n_terms;
    logic signed [9:0]        yd_l, yd_r, ud, vd;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        yd_l = signed'({2'b00, i_pair.luma_l}) - Y_OFS;
        yd_r = signed'({2'b00, i_pair.luma_r}) - Y_OFS;
        ud   = signed'({2'b00, i_pair.cb}) - C_OFS;
        vd   = signed'({2'b00, i_pair.cr}) - C_OFS;
        n_terms.y_l       = TERM_W'(yd_l) * C_Y;
        n_terms.y_r       = TERM_W'(yd_r) * C_Y;
        n_terms.t_b       = TERM_W'(ud) * C_BU;
        n_terms.t_g       = -(TERM_W'(ud) * C_GU) - (TERM_W'(vd) * C_GV);
        n_terms.t_r       = TERM_W'(vd) * C_RV;
        n_terms.row_end   = i_pair.row_end;
        n_terms.frame_end = i_pair.frame_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_terms <= n_terms;
        end
    end

    assign o_valid = r_valid;
    assign o_terms = r_terms;

endmodule

[hw/rtl/yuv2bgr_clamp.sv]
// ----------------------------------------------------------------------------
// yuv2bgr_clamp
// Stage 3: sum, round, floor shift and clamp to a byte; output register.
// ----------------------------------------------------------------------------
module yuv2bgr_clamp (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  yuv2bgr_pkg::t_terms    i_terms,
    output logic                   o_valid,
    input  logic                   i_ready,
    output yuv2bgr_pkg::t_bgr      o_bgr
);
    import yuv2bgr_pkg::*;

    logic   r_valid;
    t_bgr   r_bgr;
    t_bgr   n_bgr;

    function automatic logic [SAMPLE_W-1:0] chan(
        input logic signed [TERM_W-1:0] y,
        input logic signed [TERM_W-1:0] t
    );
        logic signed [SUM_W-1:0] s;
        logic signed [SUM_W-1:0] q;
        s = SUM_W'(y) + SUM_W'(t) + ROUND;
        q = s >>> 8;
        if (q < 0) begin
            chan = '0;
        end else if (q > SUM_W'(BYTE_MAX)) begin
            chan = BYTE_MAX;
        end else begin
            chan = q[SAMPLE_W-1:0];
        end
    endfunction

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        n_bgr.blue_l    = chan(i_terms.y_l, i_terms.t_b);
        n_bgr.green_l   = chan(i_terms.y_l, i_terms.t_g);
        n_bgr.red_l     = chan(i_terms.y_l, i_terms.t_r);
        n_bgr.blue_r    = chan(i_terms.y_r, i_terms.t_b);
        n_bgr.green_r   = chan(i_terms.y_r, i_terms.t_g);
        n_bgr.red_r     = chan(i_terms.y_r, i_terms.t_r);
        n_bgr.row_end   = i_terms.row_end;
        n_bgr.frame_end = i_terms.frame_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_bgr <= n_bgr;
        end
    end

    assign o_valid = r_valid;
    assign o_bgr   = r_bgr;

endmodule

[hw/rtl/yuv420_to_bgr_pixel_converter_unit.sv]
// ----------------------------------------------------------------------------
// yuv420_to_bgr_pixel_converter_unit
// Raster 4:2:0 luma-pair stream to BGR pixel pairs, integer BT.601.
//
//  Channel  Dir  Carries                                      Transfer when
//  i_pix    in   luma_left/right, chroma_u/v                  valid & ready
//  o_bgr    out  blue/green/red left+right, row_end/frame_end valid & ready
//  i_cfg    in   index (0 width_pairs, 1 frame_rows), data    valid & ready
//
// Three register stages: line-store read, coefficient products, sum/clamp.
// One pair per clock sustained while the output is ready. Each stage holds
// its item under back-pressure and fills its bubble, so input is taken while
// a result waits in the output register if stage 1 or stage 2 is empty.
// Synchronous active-low reset clears counters, valids and config (960/1080);
// the chroma line store is not cleared and needs no clearing pass.
// Config is always ready; write it only while the block is idle.
// ----------------------------------------------------------------------------
module yuv420_to_bgr_pixel_converter_unit #(
    parameter int MAX_LINE_PAIRS = 2048
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    yuv2bgr_cfg_if.sink   i_cfg,
    yuv2bgr_pix_if.sink   i_pix,
    yuv2bgr_bgr_if.source o_bgr
);
    import yuv2bgr_pkg::*;

    // stage 1 -> 2
    logic   s1_valid, s1_ready;
    t_pair  s1_pair;
    // stage 2 -> 3
    logic   s2_valid, s2_ready;
    t_terms s2_terms;
    // stage 3 -> port
    t_bgr   s3_bgr;

    // counters, line store, chroma choice
    yuv2bgr_front #(
        .MAX_LINE_PAIRS (MAX_LINE_PAIRS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .i_pix   (i_pix),
        .o_valid (s1_valid),
        .i_ready (s1_ready),
        .o_pair  (s1_pair)
    );

    // scaled luma and chroma contributions
    yuv2bgr_terms u_terms (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .o_ready (s1_ready),
        .i_pair  (s1_pair),
        .o_valid (s2_valid),
        .i_ready (s2_ready),
        .o_terms (s2_terms)
    );

    // rounding, floor shift, clamp; output register
    yuv2bgr_clamp u_clamp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s2_valid),
        .o_ready (s2_ready),
        .i_terms (s2_terms),
        .o_valid (o_bgr.valid),
        .i_ready (o_bgr.ready),
        .o_bgr   (s3_bgr)
    );

    assign o_bgr.blue_left   = s3_bgr.blue_l;
    assign o_bgr.green_left  = s3_bgr.green_l;
    assign o_bgr.red_left    = s3_bgr.red_l;
    assign o_bgr.blue_right  = s3_bgr.blue_r;
    assign o_bgr.green_right = s3_bgr.green_r;
    assign o_bgr.red_right   = s3_bgr.red_r;
    assign o_bgr.row_end     = s3_bgr.row_end;
    assign o_bgr.frame_end   = s3_bgr.frame_end;

endmodule

[dv/yuv2bgr_pair_checker.sv]
// ----------------------------------------------------------------------------
// yuv2bgr_pair_checker
// Passive checker for the 4:2:0 to BGR converter. It follows register
// writes and pixel transfers, predicts each BGR pair in order, and compares
// every output transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module yuv2bgr_pair_checker #(
    parameter int MAX_LINE_PAIRS = 2048
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    yuv2bgr_cfg_if        i_cfg,
    yuv2bgr_pix_if        i_pix,
    yuv2bgr_bgr_if        i_bgr,
    output int            o_err_count,
    output int            o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import yuv2bgr_pkg::*;

    localparam int K_Y      = 298;
    localparam int K_BU     = 516;
    localparam int K_GU     = 100;
    localparam int K_GV     = 208;
    localparam int K_RV     = 409;
    localparam int ROWS_MAX = 4096;
    localparam int SHOWN    = 10;

    logic [WP_W-1:0] width_pairs_q;
    logic [FR_W-1:0] frame_rows_q;
    logic [15:0]     chroma_store [MAX_LINE_PAIRS];
    int unsigned     col_idx;
    int unsigned     row_idx;
    t_bgr            bgr_expected_q [$];
    int              err_total;

    int unsigned     wp_lim;
    int unsigned     fr_lim;
    logic [7:0]      cb_use;
    logic [7:0]      cr_use;
    logic            last_col;
    logic            last_row;
    t_bgr            want;
    t_bgr            seen;

    // (acc + 128) >> 8 with floor, then clamp to a byte
    function automatic logic [7:0] clamp_channel(input int acc);
        int scaled;
        scaled = (acc + 128) >>> 8;
        if (scaled < 0)
            return 8'd0;
        if (scaled > 255)
            return 8'd255;
        return scaled[7:0];
    endfunction

    function automatic t_bgr convert_pair(input logic [7:0] yl, input logic [7:0] yr,
                                          input logic [7:0] cb, input logic [7:0] cr,
                                          input logic row_end, input logic frame_end);
        t_bgr px;
        int   du;
        int   dv;
        int   tl;
        int   tr;
        du = int'(cb) - 128;
        dv = int'(cr) - 128;
        tl = (int'(yl) - 16) * K_Y;
        tr = (int'(yr) - 16) * K_Y;
        px.blue_l    = clamp_channel(tl + K_BU * du);
        px.green_l   = clamp_channel(tl - K_GU * du - K_GV * dv);
        px.red_l     = clamp_channel(tl + K_RV * dv);
        px.blue_r    = clamp_channel(tr + K_BU * du);
        px.green_r   = clamp_channel(tr - K_GU * du - K_GV * dv);
        px.red_r     = clamp_channel(tr + K_RV * dv);
        px.row_end   = row_end;
        px.frame_end = frame_end;
        return px;
    endfunction

    function automatic bit pair_differs(input t_bgr a, input t_bgr b);
        return (a.blue_l !== b.blue_l) || (a.green_l !== b.green_l) ||
               (a.red_l !== b.red_l) || (a.blue_r !== b.blue_r) ||
               (a.green_r !== b.green_r) || (a.red_r !== b.red_r) ||
               (a.row_end !== b.row_end) || (a.frame_end !== b.frame_end);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            width_pairs_q = WP_W'(960);
            frame_rows_q  = FR_W'(1080);
            col_idx       = 0;
            row_idx       = 0;
            err_total     = 0;
            bgr_expected_q.delete();
        end else begin
            // output side first: a result never belongs to this edge's input
            if (i_bgr.valid && i_bgr.ready) begin
                seen.blue_l    = i_bgr.blue_left;
                seen.green_l   = i_bgr.green_left;
                seen.red_l     = i_bgr.red_left;
                seen.blue_r    = i_bgr.blue_right;
                seen.green_r   = i_bgr.green_right;
                seen.red_r     = i_bgr.red_right;
                seen.row_end   = i_bgr.row_end;
                seen.frame_end = i_bgr.frame_end;
                if (bgr_expected_q.size() == 0) begin
                    err_total++;
                    if (err_total <= SHOWN)
                        $display("%0t: bgr transfer with nothing expected", $time);
                end else begin
                    want = bgr_expected_q.pop_front();
                    if (pair_differs(want, seen)) begin
                        err_total++;
                        if (err_total <= SHOWN) begin
                            $display("%0t: bgr mismatch, expected L %h/%h/%h R %h/%h/%h ends %b%b",
                                     $time, want.blue_l, want.green_l, want.red_l,
                                     want.blue_r, want.green_r, want.red_r,
                                     want.row_end, want.frame_end);
                            $display("%0t: bgr mismatch, actual   L %h/%h/%h R %h/%h/%h ends %b%b",
                                     $time, seen.blue_l, seen.green_l, seen.red_l,
                                     seen.blue_r, seen.green_r, seen.red_r,
                                     seen.row_end, seen.frame_end);
                        end
                    end
                end
            end

            if (i_cfg.valid && i_cfg.ready) begin
                if (i_cfg.index == CFG_WIDTH_PAIRS)
                    width_pairs_q = i_cfg.data[WP_W-1:0];
                else
                    frame_rows_q = i_cfg.data[FR_W-1:0];
            end

            if (i_pix.valid && i_pix.ready) begin
                wp_lim = (width_pairs_q == 0) ? 1 : int'(width_pairs_q);
                if (wp_lim > MAX_LINE_PAIRS)
                    wp_lim = MAX_LINE_PAIRS;
                fr_lim = (frame_rows_q == 0) ? 1 : int'(frame_rows_q);
                if (fr_lim > ROWS_MAX)
                    fr_lim = ROWS_MAX;

                // even rows take fresh chroma and store it, odd rows reuse it
                if (row_idx[0] == 1'b0) begin
                    cb_use = i_pix.chroma_u;
                    cr_use = i_pix.chroma_v;
                    chroma_store[col_idx % MAX_LINE_PAIRS] = {cb_use, cr_use};
                end else begin
                    {cb_use, cr_use} = chroma_store[col_idx % MAX_LINE_PAIRS];
                end

                last_col = (col_idx + 1 >= wp_lim);
                last_row = last_col && (row_idx + 1 >= fr_lim);
                bgr_expected_q = {bgr_expected_q,
                                  convert_pair(i_pix.luma_left, i_pix.luma_right,
                                               cb_use, cr_use, last_col, last_row)};
                if (last_col) begin
                    col_idx = 0;
                    row_idx = last_row ? 0 : row_idx + 1;
                end else begin
                    col_idx++;
                end
            end
        end
        o_pending   <= bgr_expected_q.size();
        o_err_count <= err_total;
    end

endmodule

[dv/yuv420_to_bgr_pixel_converter_unit_tb.sv]
// ----------------------------------------------------------------------------
// yuv420_to_bgr_pixel_converter_unit_tb
// Drives luma/chroma pair streams through the converter under a sweep of
// row widths and frame heights, with random gaps on both channels. The
// checker beside the block predicts every BGR pair; this module only makes
// stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module yuv420_to_bgr_pixel_converter_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import yuv2bgr_pkg::*;

    localparam int          MAX_LINE_PAIRS = 2048;
    localparam int          ROWS_MAX       = 4096;
    localparam int          RANDOM_ITEMS   = 500;
    localparam int          WIDE_ITEMS     = 40;
    localparam int          TALL_ITEMS     = 40;
    localparam int          TAIL_CYCLES    = 8;       // idle clocks before the verdict
    localparam int unsigned CYCLE_LIMIT    = 200000;

    // directed pairs at reset settings: {luma_left, luma_right, cb, cr}
    localparam logic [31:0] DIRECTED [10] = '{
        {8'd0,   8'd255, 8'd128, 8'd128},   // luma extremes, neutral chroma
        {8'd16,  8'd235, 8'd128, 8'd128},   // studio black and white
        {8'd255, 8'd255, 8'd255, 8'd255},   // everything pinned high
        {8'd0,   8'd0,   8'd0,   8'd0},     // everything pinned low
        {8'd255, 8'd0,   8'd0,   8'd255},
        {8'd0,   8'd255, 8'd255, 8'd0},
        {8'd128, 8'd128, 8'd0,   8'd128},   // chroma extremes one at a time
        {8'd128, 8'd128, 8'd255, 8'd128},
        {8'd128, 8'd128, 8'd128, 8'd0},
        {8'd128, 8'd128, 8'd128, 8'd255}
    };

    logic i_clk;
    logic i_rst_n;
    int   err_count;
    int   pending;

    yuv2bgr_cfg_if cfg_if ();
    yuv2bgr_pix_if pix_if ();
    yuv2bgr_bgr_if bgr_if ();

    yuv420_to_bgr_pixel_converter_unit #(
        .MAX_LINE_PAIRS (MAX_LINE_PAIRS)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_pix   (pix_if),
        .o_bgr   (bgr_if)
    );

    yuv2bgr_pair_checker #(
        .MAX_LINE_PAIRS (MAX_LINE_PAIRS)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg_if),
        .i_pix       (pix_if),
        .i_bgr       (bgr_if),
        .o_err_count (err_count),
        .o_pending   (pending)
    );

    // Idle percentages per channel, changed between phases.
    int unsigned snd_idle_pct = 28;
    int unsigned rcv_idle_pct = 47;

    // Where the stream stands, kept only to shape stimulus: an odd row must
    // never read a line-store column that no even row has written yet.
    int unsigned wp_eff       = 960;
    int unsigned fr_eff       = 1080;
    int unsigned pos_col      = 0;
    int unsigned pos_row      = 0;
    int unsigned written_cols = 0;

    int unsigned cycle_count  = 0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("yuv420_to_bgr_pixel_converter_unit_tb: done, errors");
            $finish;
        end
    end

    // Output back-pressure: one fresh decision per clock.
    always @(posedge i_clk) begin
        bgr_if.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end

    function automatic int unsigned eff_width(input logic [12:0] value);
        int unsigned w;
        w = value[WP_W-1:0];
        if (w == 0)
            return 1;
        return (w > MAX_LINE_PAIRS) ? MAX_LINE_PAIRS : w;
    endfunction

    // Both registers back to back; valid stays high across the pair.
    task automatic configure(input logic [12:0] wp_val, input logic [12:0] fr_val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= CFG_WIDTH_PAIRS;
        cfg_if.data  <= wp_val;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.index <= CFG_FRAME_ROWS;
        cfg_if.data  <= fr_val;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        wp_eff = eff_width(wp_val);
        fr_eff = (fr_val == 0) ? 1 : ((fr_val > ROWS_MAX) ? ROWS_MAX : fr_val);
    endtask

    // One pixel-pair transfer, with random idle cycles ahead of it.
    task automatic send_pair(input logic [7:0] yl, input logic [7:0] yr,
                             input logic [7:0] cb, input logic [7:0] cr);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            pix_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix_if.valid      <= 1'b1;
        pix_if.luma_left  <= yl;
        pix_if.luma_right <= yr;
        pix_if.chroma_u   <= cb;
        pix_if.chroma_v   <= cr;
        do @(posedge i_clk); while (!(pix_if.valid && pix_if.ready));
        // even rows extend the written prefix of the line store
        if (!pos_row[0] && pos_col + 1 > written_cols)
            written_cols = pos_col + 1;
        if (pos_col + 1 >= wp_eff) begin
            pos_col = 0;
            pos_row = (pos_row + 1 >= fr_eff) ? 0 : pos_row + 1;
        end else begin
            pos_col++;
        end
    endtask

    task automatic send_random(input int unsigned count);
        repeat (count)
            send_pair(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    endtask

    // Stop sending and wait until every predicted pair has come out.
    task automatic drain;
        pix_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
    endtask

    initial begin
        int unsigned random_sent;
        int unsigned n;
        logic [12:0] wp_val;
        logic [12:0] fr_val;

        i_rst_n           <= 1'b0;
        cfg_if.valid      <= 1'b0;
        cfg_if.index      <= CFG_WIDTH_PAIRS;
        cfg_if.data       <= '0;
        pix_if.valid      <= 1'b0;
        pix_if.luma_left  <= '0;
        pix_if.luma_right <= '0;
        pix_if.chroma_u   <= '0;
        pix_if.chroma_v   <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: colour extremes at the reset settings (960 x 1080).
        foreach (DIRECTED[i])
            send_pair(DIRECTED[i][31:24], DIRECTED[i][23:16],
                      DIRECTED[i][15:8], DIRECTED[i][7:0]);
        drain();

        // Width shrunk below the current column: the row ends on the next
        // transfer. Then an odd row reuses stored chroma while its own input
        // chroma is junk.
        configure(13'd3, 13'd2);
        send_random(10);
        drain();

        // Zero in both registers acts as one: every pair ends row and frame.
        configure(13'd0, 13'd0);
        send_random(4);
        drain();

        // Random sweep of small geometries; most writes land mid-row.
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            if (random_sent < RANDOM_ITEMS / 3) begin
                snd_idle_pct = 28;
                rcv_idle_pct = 47;
            end else if (random_sent < 2 * RANDOM_ITEMS / 3) begin
                snd_idle_pct = 47;
                rcv_idle_pct = 28;
            end else begin
                snd_idle_pct = 0;
                rcv_idle_pct = 0;
            end
            wp_val = ($urandom_range(0, 15) == 0) ? 13'd2048 : 13'($urandom_range(0, 9));
            fr_val = ($urandom_range(0, 15) == 0) ? 13'd4096 : 13'($urandom_range(0, 6));
            // an odd row may only read what the last even row wrote
            if (pos_row[0] && eff_width(wp_val) > written_cols)
                wp_val = 13'(written_cols);
            configure(wp_val, fr_val);
            n = $urandom_range(4, 40);
            send_random(n);
            random_sent += n;
            drain();
        end

        // Widest row. First end the current row as the last of a frame, so
        // the wide row starts even at column zero.
        if (pos_col != 0 || pos_row != 0) begin
            configure(13'd1, 13'd1);
            send_random(1);
            drain();
        end
        // all ones in the width register saturates at the line-store depth,
        // so no row end within these pairs
        configure(13'h1FFF, 13'd2);
        send_random(WIDE_ITEMS);
        drain();

        // One pair per row; all ones clamps to 4096 rows, no frame end here.
        configure(13'd1, 13'h1FFF);
        send_random(TALL_ITEMS);
        drain();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_count == 0 && pending == 0)
            $display("yuv420_to_bgr_pixel_converter_unit_tb: done, clean");
        else
            $display("yuv420_to_bgr_pixel_converter_unit_tb: done, errors");
        $finish;
    end

endmodule
